FILE: hdl/sr_pkg.sv
// ----------------------------------------------------------------------------
// Schroeder reverb package
// Shared widths, register codes, command/status bundles and arithmetic helpers.
// ----------------------------------------------------------------------------
package sr_pkg;

  localparam int SAMPLE_BITS   = 24;
  localparam int STORE_BITS    = SAMPLE_BITS + 4;
  localparam int GAIN_BITS     = 16;
  localparam int PROD_BITS     = STORE_BITS + GAIN_BITS + 1;
  localparam int WIDE_BITS     = 32;
  localparam int CH_BITS       = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int COMB_REG_BITS = 13;
  localparam int AP_REG_BITS   = 12;

  localparam int MIN_LEN   = 16;
  localparam int FB_BASE   = 13107;
  localparam int FB_SLOPE  = 42598;
  localparam int WET_SLOPE = 52429;
  localparam int ROUND_HALF = 32768;

  localparam int CHANNELS_DEF        = 8;
  localparam int MAX_COMB_LEN_DEF    = 4096;
  localparam int MAX_ALLPASS_LEN_DEF = 2048;

  localparam int COMB_LEN_RST_1 = 1116;
  localparam int COMB_LEN_RST_2 = 1188;
  localparam int COMB_LEN_RST_3 = 1277;
  localparam int COMB_LEN_RST_4 = 1356;
  localparam int AP_LEN_RST_1   = 556;
  localparam int AP_LEN_RST_2   = 441;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STORE_BITS-1:0]  store_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [WIDE_BITS-1:0]   wide_t;

  localparam wide_t STORE_MAX  = (32'sd1 <<< (STORE_BITS - 1)) - 32'sd1;
  localparam wide_t STORE_MIN  = -STORE_MAX - 32'sd1;
  localparam wide_t SAMPLE_MAX = (32'sd1 <<< (SAMPLE_BITS - 1)) - 32'sd1;
  localparam wide_t SAMPLE_MIN = -SAMPLE_MAX - 32'sd1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DECAY  = 3'd0,
    REG_COMB_1 = 3'd1,
    REG_COMB_2 = 3'd2,
    REG_COMB_3 = 3'd3,
    REG_COMB_4 = 3'd4,
    REG_AP_1   = 3'd5,
    REG_AP_2   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic       load;
    logic       pass;
    logic       clr_start;
    logic       clr_step;
    logic       comb_rd;
    logic       comb_mul;
    logic       comb_wr;
    logic       ap_rd;
    logic       ap_wr;
    logic       wet_mul;
    logic       wet_add;
    logic       push;
    logic [1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic bypass;
    logic clr_last;
    logic out_free;
  } stat_t;

  function automatic int clamp_len(input int v, input int maxlen);
    return (v < MIN_LEN) ? MIN_LEN : ((v > maxlen) ? maxlen : v);
  endfunction

  function automatic store_t sat_store(input wide_t v);
    wide_t r;
    r = (v > STORE_MAX) ? STORE_MAX : ((v < STORE_MIN) ? STORE_MIN : v);
    return store_t'(r);
  endfunction

  function automatic sample_t sat_sample(input wide_t v);
    wide_t r;
    r = (v > SAMPLE_MAX) ? SAMPLE_MAX : ((v < SAMPLE_MIN) ? SAMPLE_MIN : v);
    return sample_t'(r);
  endfunction

  // Gain product back to sample scale, rounding half up.
  function automatic wide_t round_gain(input prod_t p);
    prod_t s;
    s = p + prod_t'(ROUND_HALF);
    return wide_t'(s >>> GAIN_BITS);
  endfunction

endpackage

FILE: hdl/sr_if.sv
// ----------------------------------------------------------------------------
// Schroeder reverb stream interfaces
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface sr_in_if;
  logic                                valid;
  logic                                ready;
  logic [sr_pkg::CH_BITS-1:0]          channel;
  logic signed [sr_pkg::SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, channel, sample_in, input ready);
  modport sink   (input valid, channel, sample_in, output ready);
endinterface

interface sr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sr_pkg::SAMPLE_BITS-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

FILE: hdl/schroeder_reverb.sv
// ----------------------------------------------------------------------------
// Schroeder reverb, four combs and two allpasses per channel
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake      Word
// in_i      in   valid/ready    channel[2:0], sample_in[23:0] signed Q1.23
// out_o     out  valid/ready    sample_out[23:0] signed Q1.23, saturated
// cfg       in   cfg_we_i       cfg_idx_i[2:0], cfg_data_i[15:0], no read-back
//
// A reverb word runs from acceptance to the output register through a check
// step, three per comb (read, multiply, write) over one comb memory port, two
// per allpass over one allpass port, two for the wet gain on the shared
// multiplier and one to load the output register. A bypassed word (decay zero
// or channel out of range) goes from the check step to the output load; the
// next word is taken in the idle state after the load. After reset, or a write
// of zero decay or any length while idle or sweeping, the stores are swept to
// zero, one entry a cycle, over max(CHANNELS*4*MAX_COMB_LEN,
// CHANNELS*2*MAX_ALLPASS_LEN) entries (131072 at defaults); no word is taken.
// The output register holds a finished word while the next one is accepted;
// a word still untaken there stalls the next result and hence the input.
// ----------------------------------------------------------------------------
module schroeder_reverb #(
  parameter int CHANNELS        = sr_pkg::CHANNELS_DEF,
  parameter int MAX_COMB_LEN    = sr_pkg::MAX_COMB_LEN_DEF,
  parameter int MAX_ALLPASS_LEN = sr_pkg::MAX_ALLPASS_LEN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  sr_in_if.sink                            in_i,
  sr_out_if.source                         out_o,
  input  logic                             cfg_we_i,
  input  logic [sr_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [sr_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int CLW = $clog2(MAX_COMB_LEN + 1);
  localparam int ALW = $clog2(MAX_ALLPASS_LEN + 1);

  sr_pkg::cmd_t                  cmd;
  sr_pkg::stat_t                 stat;
  logic                          decay_nz;
  logic                          clr_req;
  logic [sr_pkg::GAIN_BITS-1:0]  fb, wet;
  logic [3:0][CLW-1:0]           comb_len;
  logic [1:0][ALW-1:0]           ap_len;

  // configuration: gains derived and lengths clamped on write
  sr_cfg #(
    .MAX_COMB_LEN   (MAX_COMB_LEN),
    .MAX_ALLPASS_LEN(MAX_ALLPASS_LEN)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .decay_nz_o (decay_nz),
    .fb_o       (fb),
    .wet_o      (wet),
    .comb_len_o (comb_len),
    .ap_len_o   (ap_len),
    .clr_req_o  (clr_req)
  );

  // sequencer: accept only when idle, hold in the sweep after a clear
  sr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .clr_req_i  (clr_req),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // stores, positions, shared multiplier and output register
  sr_dp #(
    .CHANNELS       (CHANNELS),
    .MAX_COMB_LEN   (MAX_COMB_LEN),
    .MAX_ALLPASS_LEN(MAX_ALLPASS_LEN)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .channel_i   (in_i.channel),
    .sample_i    (in_i.sample_in),
    .decay_nz_i  (decay_nz),
    .fb_i        (fb),
    .wet_i       (wet),
    .comb_len_i  (comb_len),
    .ap_len_i    (ap_len),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.sample_out)
  );

endmodule

FILE: hdl/sr_cfg.sv
// ----------------------------------------------------------------------------
// Schroeder reverb configuration registers
// Decay, derived gains and clamped delay lengths; flags store clearing.
// ----------------------------------------------------------------------------
module sr_cfg #(
  parameter int MAX_COMB_LEN    = sr_pkg::MAX_COMB_LEN_DEF,
  parameter int MAX_ALLPASS_LEN = sr_pkg::MAX_ALLPASS_LEN_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sr_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [sr_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  output logic                               decay_nz_o,
  output logic [sr_pkg::GAIN_BITS-1:0]       fb_o,
  output logic [sr_pkg::GAIN_BITS-1:0]       wet_o,
  output logic [3:0][$clog2(MAX_COMB_LEN+1)-1:0]    comb_len_o,
  output logic [1:0][$clog2(MAX_ALLPASS_LEN+1)-1:0] ap_len_o,
  output logic                               clr_req_o
);

  localparam int CLW = $clog2(MAX_COMB_LEN + 1);
  localparam int ALW = $clog2(MAX_ALLPASS_LEN + 1);

  logic                             decay_nz_q;
  logic [sr_pkg::GAIN_BITS-1:0]     fb_q, wet_q;
  logic [3:0][CLW-1:0]              comb_len_q;
  logic [1:0][ALW-1:0]              ap_len_q;
  logic [CLW-1:0]                   comb_new;
  logic [ALW-1:0]                   ap_new;

  assign comb_new = CLW'(sr_pkg::clamp_len(
                      int'(cfg_data_i[sr_pkg::COMB_REG_BITS-1:0]), MAX_COMB_LEN));
  assign ap_new   = ALW'(sr_pkg::clamp_len(
                      int'(cfg_data_i[sr_pkg::AP_REG_BITS-1:0]), MAX_ALLPASS_LEN));

  always_comb begin
    clr_req_o = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i) inside
        sr_pkg::REG_DECAY: clr_req_o = (cfg_data_i == '0);
        [sr_pkg::REG_COMB_1:sr_pkg::REG_AP_2]: clr_req_o = 1'b1;
        default: clr_req_o = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_nz_q <= 1'b0;
      fb_q       <= sr_pkg::GAIN_BITS'(sr_pkg::FB_BASE);
      wet_q      <= '0;
      comb_len_q[0] <= CLW'(sr_pkg::clamp_len(sr_pkg::COMB_LEN_RST_1, MAX_COMB_LEN));
      comb_len_q[1] <= CLW'(sr_pkg::clamp_len(sr_pkg::COMB_LEN_RST_2, MAX_COMB_LEN));
      comb_len_q[2] <= CLW'(sr_pkg::clamp_len(sr_pkg::COMB_LEN_RST_3, MAX_COMB_LEN));
      comb_len_q[3] <= CLW'(sr_pkg::clamp_len(sr_pkg::COMB_LEN_RST_4, MAX_COMB_LEN));
      ap_len_q[0]   <= ALW'(sr_pkg::clamp_len(sr_pkg::AP_LEN_RST_1, MAX_ALLPASS_LEN));
      ap_len_q[1]   <= ALW'(sr_pkg::clamp_len(sr_pkg::AP_LEN_RST_2, MAX_ALLPASS_LEN));
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sr_pkg::REG_DECAY: begin
          decay_nz_q <= (cfg_data_i != '0);
          fb_q  <= sr_pkg::GAIN_BITS'(sr_pkg::FB_BASE +
                   ((32'(cfg_data_i) * sr_pkg::FB_SLOPE) >> sr_pkg::GAIN_BITS));
          wet_q <= sr_pkg::GAIN_BITS'(
                   (32'(cfg_data_i) * sr_pkg::WET_SLOPE) >> sr_pkg::GAIN_BITS);
        end
        sr_pkg::REG_COMB_1: comb_len_q[0] <= comb_new;
        sr_pkg::REG_COMB_2: comb_len_q[1] <= comb_new;
        sr_pkg::REG_COMB_3: comb_len_q[2] <= comb_new;
        sr_pkg::REG_COMB_4: comb_len_q[3] <= comb_new;
        sr_pkg::REG_AP_1:   ap_len_q[0]   <= ap_new;
        sr_pkg::REG_AP_2:   ap_len_q[1]   <= ap_new;
        default: ;
      endcase
    end
  end

  assign decay_nz_o = decay_nz_q;
  assign fb_o       = fb_q;
  assign wet_o      = wet_q;
  assign comb_len_o = comb_len_q;
  assign ap_len_o   = ap_len_q;

endmodule

FILE: hdl/sr_ctrl.sv
// ----------------------------------------------------------------------------
// Schroeder reverb controller
// Sequences the clearing sweep and the per-word comb/allpass/wet steps.
// ----------------------------------------------------------------------------
module sr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          clr_req_i,
  input  sr_pkg::stat_t stat_i,
  output sr_pkg::cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CLEAR = 11'b000_0000_0010,
    S_CHK   = 11'b000_0000_0100,
    S_CRD   = 11'b000_0000_1000,
    S_CMUL  = 11'b000_0001_0000,
    S_CWR   = 11'b000_0010_0000,
    S_ARD   = 11'b000_0100_0000,
    S_AWR   = 11'b000_1000_0000,
    S_WMUL  = 11'b001_0000_0000,
    S_WET   = 11'b010_0000_0000,
    S_OUT   = 11'b100_0000_0000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       accept;

  // refuse a word while a clear is requested, so none is taken and dropped
  assign in_ready_o = (state_q == S_IDLE) && !clr_req_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    cmd_o.idx = idx_q;
    case (state_q)
      S_IDLE: begin
        if (clr_req_i) begin
          cmd_o.clr_start = 1'b1;
          state_d = S_CLEAR;
        end else if (accept) begin
          cmd_o.load = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CLEAR: begin
        if (clr_req_i) begin
          cmd_o.clr_start = 1'b1;
        end else begin
          cmd_o.clr_step = 1'b1;
          if (stat_i.clr_last) state_d = S_IDLE;
        end
      end
      S_CHK: begin
        idx_d = '0;
        if (stat_i.bypass) begin
          cmd_o.pass = 1'b1;
          state_d = S_OUT;
        end else begin
          state_d = S_CRD;
        end
      end
      S_CRD: begin
        cmd_o.comb_rd = 1'b1;
        state_d = S_CMUL;
      end
      S_CMUL: begin
        cmd_o.comb_mul = 1'b1;
        state_d = S_CWR;
      end
      S_CWR: begin
        cmd_o.comb_wr = 1'b1;
        idx_d = idx_q + 2'd1;
        state_d = (idx_q == 2'd3) ? S_ARD : S_CRD;
      end
      S_ARD: begin
        cmd_o.ap_rd = 1'b1;
        state_d = S_AWR;
      end
      S_AWR: begin
        cmd_o.ap_wr = 1'b1;
        idx_d = idx_q + 2'd1;
        state_d = (idx_q == 2'd1) ? S_WMUL : S_ARD;
      end
      S_WMUL: begin
        cmd_o.wet_mul = 1'b1;
        state_d = S_WET;
      end
      S_WET: begin
        cmd_o.wet_add = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  a_accept_to_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !clr_req_i |=> state_q == S_CHK)
    else $error("accepted word did not move to the check step");

  a_clear_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_req_i && (state_q == S_IDLE || state_q == S_CLEAR) |=> state_q == S_CLEAR)
    else $error("clear request did not start the sweep");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

endmodule

FILE: hdl/sr_dp.sv
// ----------------------------------------------------------------------------
// Schroeder reverb datapath
// Delay memories, positions, shared gain multiplier and output register.
// ----------------------------------------------------------------------------
module sr_dp #(
  parameter int CHANNELS        = sr_pkg::CHANNELS_DEF,
  parameter int MAX_COMB_LEN    = sr_pkg::MAX_COMB_LEN_DEF,
  parameter int MAX_ALLPASS_LEN = sr_pkg::MAX_ALLPASS_LEN_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  sr_pkg::cmd_t                             cmd_i,
  output sr_pkg::stat_t                            stat_o,
  input  logic [sr_pkg::CH_BITS-1:0]               channel_i,
  input  sr_pkg::sample_t                          sample_i,
  input  logic                                     decay_nz_i,
  input  logic [sr_pkg::GAIN_BITS-1:0]             fb_i,
  input  logic [sr_pkg::GAIN_BITS-1:0]             wet_i,
  input  logic [3:0][$clog2(MAX_COMB_LEN+1)-1:0]    comb_len_i,
  input  logic [1:0][$clog2(MAX_ALLPASS_LEN+1)-1:0] ap_len_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output sr_pkg::sample_t                          out_data_o
);

  localparam int CPW    = $clog2(MAX_COMB_LEN);
  localparam int APW    = $clog2(MAX_ALLPASS_LEN);
  localparam int CSLOTS = CHANNELS * 4;
  localparam int ASLOTS = CHANNELS * 2;
  localparam int CSW    = $clog2(CSLOTS);
  localparam int ASW    = $clog2(ASLOTS);
  localparam int CDEPTH = CSLOTS * MAX_COMB_LEN;
  localparam int ADEPTH = ASLOTS * MAX_ALLPASS_LEN;
  localparam int CAW    = $clog2(CDEPTH);
  localparam int AAW    = $clog2(ADEPTH);
  localparam int SDEPTH = (CDEPTH > ADEPTH) ? CDEPTH : ADEPTH;
  localparam int SWW    = $clog2(SDEPTH);

  sr_pkg::store_t comb_mem [CDEPTH];
  sr_pkg::store_t ap_mem   [ADEPTH];

  logic [CPW-1:0] comb_pos_q [CSLOTS];
  logic [APW-1:0] ap_pos_q   [ASLOTS];
  logic [SWW-1:0] clr_cnt_q;

  logic [sr_pkg::CH_BITS-1:0] ch_q;
  sr_pkg::sample_t x_q, res_q, out_data_q;
  sr_pkg::store_t  comb_rd_q, ap_rd_q, verb_q, ap_y, ap_wd, comb_wd;
  sr_pkg::prod_t   prod_q, prod_d;
  sr_pkg::wide_t   acc_q;
  logic            out_valid_q;

  logic [CAW-1:0] caddr_q, caddr_d, comb_wa;
  logic [AAW-1:0] aaddr_q, aaddr_d, ap_wa;
  logic [CSW-1:0] cslot;
  logic [ASW-1:0] aslot;
  logic [CPW-1:0] cnext;
  logic [APW-1:0] anext;
  int             cinc, ainc;
  logic           comb_we, ap_we, clr_comb, clr_ap;
  sr_pkg::store_t mul_a;
  logic [sr_pkg::GAIN_BITS-1:0] mul_b;

  // slot and advanced position for the comb or allpass in hand
  assign cslot = CSW'({ch_q, cmd_i.idx});
  assign aslot = ASW'({ch_q, cmd_i.idx[0]});
  assign cinc  = int'(comb_pos_q[cslot]) + 1;
  assign ainc  = int'(ap_pos_q[aslot]) + 1;
  assign cnext = (cinc >= int'(comb_len_i[cmd_i.idx])) ? '0 : CPW'(cinc);
  assign anext = (ainc >= int'(ap_len_i[cmd_i.idx[0]])) ? '0 : APW'(ainc);
  assign caddr_d = CAW'(int'(cslot) * MAX_COMB_LEN + int'(cnext));
  assign aaddr_d = AAW'(int'(aslot) * MAX_ALLPASS_LEN + int'(anext));

  // one multiplier shared by feedback and wet gain
  assign mul_a  = cmd_i.comb_mul ? comb_rd_q : verb_q;
  assign mul_b  = cmd_i.comb_mul ? fb_i : wet_i;
  assign prod_d = mul_a * $signed({1'b0, mul_b});

  assign comb_wd = sr_pkg::sat_store(sr_pkg::wide_t'(x_q) + sr_pkg::round_gain(prod_q));
  assign ap_y    = sr_pkg::sat_store(sr_pkg::wide_t'(ap_rd_q) -
                                     (sr_pkg::wide_t'(verb_q) >>> 1));
  assign ap_wd   = sr_pkg::sat_store(sr_pkg::wide_t'(verb_q) +
                                     (sr_pkg::wide_t'(ap_y) >>> 1));

  assign clr_comb = cmd_i.clr_step && (int'(clr_cnt_q) < CDEPTH);
  assign clr_ap   = cmd_i.clr_step && (int'(clr_cnt_q) < ADEPTH);
  assign comb_we  = clr_comb || cmd_i.comb_wr;
  assign ap_we    = clr_ap || cmd_i.ap_wr;
  assign comb_wa  = cmd_i.clr_step ? CAW'(clr_cnt_q) : caddr_q;
  assign ap_wa    = cmd_i.clr_step ? AAW'(clr_cnt_q) : aaddr_q;

  always_ff @(posedge clk_i) begin
    if (comb_we) comb_mem[comb_wa] <= cmd_i.clr_step ? '0 : comb_wd;
    if (cmd_i.comb_rd) comb_rd_q <= comb_mem[caddr_d];
  end

  always_ff @(posedge clk_i) begin
    if (ap_we) ap_mem[ap_wa] <= cmd_i.clr_step ? '0 : ap_wd;
    if (cmd_i.ap_rd) ap_rd_q <= ap_mem[aaddr_d];
  end

  // positions, sweep counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CSLOTS; i++) comb_pos_q[i] <= '0;
      for (int i = 0; i < ASLOTS; i++) ap_pos_q[i] <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_start) begin
        for (int i = 0; i < CSLOTS; i++) comb_pos_q[i] <= '0;
        for (int i = 0; i < ASLOTS; i++) ap_pos_q[i] <= '0;
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + SWW'(1);
      end
      if (cmd_i.comb_rd) comb_pos_q[cslot] <= cnext;
      if (cmd_i.ap_rd) ap_pos_q[aslot] <= anext;
      if (cmd_i.push) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // word payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q  <= channel_i;
      x_q   <= sample_i;
      acc_q <= '0;
    end
    if (cmd_i.comb_rd) caddr_q <= caddr_d;
    if (cmd_i.ap_rd) aaddr_q <= aaddr_d;
    if (cmd_i.comb_mul || cmd_i.wet_mul) prod_q <= prod_d;
    if (cmd_i.comb_mul) acc_q <= acc_q + sr_pkg::wide_t'(comb_rd_q);
    if (cmd_i.comb_wr && cmd_i.idx == 2'd3) verb_q <= sr_pkg::store_t'(acc_q >>> 2);
    if (cmd_i.ap_wr) verb_q <= ap_y;
    if (cmd_i.pass) res_q <= x_q;
    if (cmd_i.wet_add)
      res_q <= sr_pkg::sat_sample(sr_pkg::wide_t'(x_q) + sr_pkg::round_gain(prod_q));
    if (cmd_i.push) out_data_q <= res_q;
  end

  assign stat_o.bypass   = !decay_nz_i || (int'(ch_q) >= CHANNELS);
  assign stat_o.clr_last = (int'(clr_cnt_q) == SDEPTH - 1);
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken word");

  a_comb_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.comb_wr |-> int'(caddr_q) < CDEPTH)
    else $error("comb write address outside the store");

  a_ap_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ap_wr |-> int'(aaddr_q) < ADEPTH)
    else $error("allpass write address outside the store");

endmodule
